@@ rtl/touch_sample_filter_unit_defines.svh @@
// Assertion macros shared by the touch filter checker.
// No dependencies; sampled on clk, disabled while rst_n is low.
`ifndef TOUCH_SAMPLE_FILTER_UNIT_DEFINES_SVH
`define TOUCH_SAMPLE_FILTER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TSF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tsf_pkg.sv @@
// Types and constants for the touch sample filter.
// No dependencies; used by the design modules, the checker and the bench.
package tsf_pkg;

    localparam int MEDIAN_COUNT   = 7;
    localparam int DEBOUNCE_READS = 2;
    localparam int SETTLE_POLLS   = 2;
    localparam int LOCK_SAMPLES   = 3;

    localparam int MEDIAN_MID = MEDIAN_COUNT / 2;
    localparam int IDX_W      = $clog2(MEDIAN_COUNT);
    localparam int CNT_W      = $clog2(MEDIAN_COUNT + 1);

    localparam logic [2:0] DOWN_MAX    = 3'd7;
    localparam logic [2:0] DOWN_REPORT = 3'(DEBOUNCE_READS + SETTLE_POLLS);
    localparam logic [2:0] DOWN_DEB    = 3'(DEBOUNCE_READS);
    localparam logic [1:0] LOCK_MAX    = 2'd3;
    localparam logic [1:0] LOCK_SLOW   = 2'(LOCK_SAMPLES);

    localparam logic [15:0] ALPHA_FAST = 16'd27853;
    localparam logic [15:0] ALPHA_SLOW = 16'd13107;
    localparam logic [16:0] Q15_ONE    = 17'd32768;
    localparam logic [12:0] Z_OFFSET   = 13'd4095;

    localparam logic [1:0] OP_OPEN   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_CLOSE  = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    localparam logic [2:0] REG_PRESS_FLOOR  = 3'd0;
    localparam logic [2:0] REG_JUMP_LIMIT   = 3'd1;
    localparam logic [2:0] REG_CAL_AX       = 3'd2;
    localparam logic [2:0] REG_CAL_BX       = 3'd3;
    localparam logic [2:0] REG_CAL_CX       = 3'd4;
    localparam logic [2:0] REG_CAL_AY       = 3'd5;
    localparam logic [2:0] REG_CAL_BY       = 3'd6;
    localparam logic [2:0] REG_CAL_CY       = 3'd7;

    typedef struct packed {
        logic [12:0]        press_floor;
        logic [11:0]        jump_limit;
        logic signed [31:0] cal_ax;
        logic signed [31:0] cal_bx;
        logic signed [31:0] cal_cx;
        logic signed [31:0] cal_ay;
        logic signed [31:0] cal_by;
        logic signed [31:0] cal_cy;
    } cfg_t;

    typedef struct packed {
        logic               issue;
        logic               clr;
        logic signed [63:0] init;
        logic signed [32:0] a;
        logic signed [20:0] b;
    } mac_op_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [11:0]      x;
        logic [11:0]      y;
    } med_wr_t;

    typedef struct packed {
        logic        done;
        logic [11:0] rx;
        logic [11:0] ry;
    } med_t;

endpackage

@@ rtl/tsf_if.sv @@
// Handshake channels of the touch filter: samples in, results out, config writes.
// No dependencies.
interface tsf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [11:0] z_one;
    logic [11:0] z_two;
    logic [11:0] x_sample;
    logic [11:0] y_sample;
    modport source (output valid, opcode, z_one, z_two, x_sample, y_sample, input ready);
    modport sink   (input valid, opcode, z_one, z_two, x_sample, y_sample, output ready);
endinterface

interface tsf_out_if;
    logic               valid;
    logic               ready;
    logic               pen_down;
    logic               need_samples;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    modport source (output valid, pen_down, need_samples, pos_x, pos_y, input ready);
    modport sink   (input valid, pen_down, need_samples, pos_x, pos_y, output ready);
endinterface

interface tsf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/tsf_cfg_regs.sv @@
// Configuration register file of the touch filter.
// Depends on tsf_pkg and tsf_if.
module tsf_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    tsf_cfg_if.sink       cfg,
    output tsf_pkg::cfg_t regs
);
    import tsf_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.press_floor  <= 13'd100;
            regs_reg.jump_limit   <= 12'd300;
            regs_reg.cal_ax       <= 32'sd65536;
            regs_reg.cal_bx       <= '0;
            regs_reg.cal_cx       <= '0;
            regs_reg.cal_ay       <= '0;
            regs_reg.cal_by       <= 32'sd65536;
            regs_reg.cal_cy       <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PRESS_FLOOR:  regs_reg.press_floor  <= cfg.data[12:0];
                REG_JUMP_LIMIT:   regs_reg.jump_limit   <= cfg.data[11:0];
                REG_CAL_AX:       regs_reg.cal_ax       <= cfg.data;
                REG_CAL_BX:       regs_reg.cal_bx       <= cfg.data;
                REG_CAL_CX:       regs_reg.cal_cx       <= cfg.data;
                REG_CAL_AY:       regs_reg.cal_ay       <= cfg.data;
                REG_CAL_BY:       regs_reg.cal_by       <= cfg.data;
                REG_CAL_CY:       regs_reg.cal_cy       <= cfg.data;
            endcase
        end
    end

endmodule

@@ rtl/tsf_median.sv @@
// Sample store and rank-scan median, x and y lanes side by side.
// Depends on tsf_pkg.
module tsf_median (
    input  logic             clk,
    input  logic             rst_n,
    input  tsf_pkg::med_wr_t wr,
    input  logic             start,
    output tsf_pkg::med_t    med
);
    import tsf_pkg::*;

    logic [11:0]      store_x [MEDIAN_COUNT];
    logic [11:0]      store_y [MEDIAN_COUNT];
    logic             busy_reg;
    logic             done_reg;
    logic [IDX_W-1:0] k_reg;
    logic [11:0]      rx_reg;
    logic [11:0]      ry_reg;
    logic [11:0]      cand_x;
    logic [11:0]      cand_y;
    logic [CNT_W-1:0] lt_x, eq_x, lt_y, eq_y;
    logic             hit_x, hit_y;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_x[wr.idx] <= wr.x;
            store_y[wr.idx] <= wr.y;
        end
    end

    // candidate k is the median when fewer than MID+1 lie below it and
    // at least MID+1 lie below or level with it
    always_comb
    begin
        cand_x = store_x[k_reg];
        cand_y = store_y[k_reg];
        lt_x = '0;
        eq_x = '0;
        lt_y = '0;
        eq_y = '0;
        for (int j = 0; j < MEDIAN_COUNT; j++)
        begin
            lt_x = lt_x + CNT_W'(store_x[j] < cand_x);
            eq_x = eq_x + CNT_W'(store_x[j] == cand_x);
            lt_y = lt_y + CNT_W'(store_y[j] < cand_y);
            eq_y = eq_y + CNT_W'(store_y[j] == cand_y);
        end
        hit_x = (lt_x <= CNT_W'(MEDIAN_MID)) && ((lt_x + eq_x) > CNT_W'(MEDIAN_MID));
        hit_y = (lt_y <= CNT_W'(MEDIAN_MID)) && ((lt_y + eq_y) > CNT_W'(MEDIAN_MID));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (k_reg == IDX_W'(MEDIAN_COUNT - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && hit_x)
            rx_reg <= cand_x;
        if (busy_reg && hit_y)
            ry_reg <= cand_y;
    end

    assign med.done = done_reg;
    assign med.rx   = rx_reg;
    assign med.ry   = ry_reg;

endmodule

@@ rtl/tsf_mac.sv @@
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on tsf_pkg. An issued op's product is registered, then added into acc.
module tsf_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  tsf_pkg::mac_op_t   op,
    output logic signed [63:0] acc
);
    import tsf_pkg::*;

    logic               vld_reg;
    logic               clr_reg;
    logic signed [63:0] init_reg;
    logic signed [53:0] prod_reg;
    logic signed [63:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            clr_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= op.issue;
            clr_reg <= op.clr;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op.a * op.b;
        init_reg <= op.init;
        if (vld_reg)
        begin
            if (clr_reg)
                acc_reg <= init_reg + 64'(prod_reg);
            else
                acc_reg <= acc_reg + 64'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

@@ rtl/touch_sample_filter_unit.sv @@
// Top level of the touch sample filter: sequencer, filter state and output beat.
// Depends on tsf_pkg, tsf_if, tsf_cfg_regs, tsf_median and tsf_mac.
//
//  channel   | dir | beat
//  samples   | in  | opcode, z_one, z_two, x_sample, y_sample
//  results   | out | pen_down, need_samples, pos_x, pos_y
//  cfg       | in  | index, data (register write)
//
// Opening pairs and pen-up closing pairs load a result beat at the accepting
// edge; xy samples give no result. A pen-down closing pair keeps samples.ready
// low through the median scan (seven candidates and the done flag), five passes
// through the one shared multiply-accumulate unit (jump test, x/y smoothing,
// x/y calibration) and the loading of the result beat. samples.ready is also
// low while a result beat is held and results.ready is low. Reset clears the
// sequencer and filter state registers, but not the sample store.
module touch_sample_filter_unit (
    input  logic    clk,
    input  logic    rst_n,
    tsf_in_if.sink  samples,
    tsf_out_if.source results,
    tsf_cfg_if.sink cfg
);
    import tsf_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MED  = 8'b0000_0010,
        ST_JMP  = 8'b0000_0100,
        ST_EWX  = 8'b0000_1000,
        ST_EWY  = 8'b0001_0000,
        ST_CALX = 8'b0010_0000,
        ST_CALY = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    cfg_t    regs;
    med_wr_t med_wr;
    med_t    med;
    mac_op_t mac_op;
    logic signed [63:0] acc;

    state_t             state_reg, state_next;
    logic [2:0]         cnt_reg;
    logic [2:0]         down_reg;
    logic [1:0]         lock_reg;
    logic [19:0]        sx_reg;
    logic [19:0]        sy_reg;
    logic [11:0]        prev_x_reg;
    logic [11:0]        prev_y_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic signed [15:0] calx_reg;
    logic               ovalid_reg;
    logic               opd_reg;
    logic               ons_reg;
    logic signed [15:0] oposx_reg;
    logic signed [15:0] oposy_reg;

    logic               accept;
    logic [12:0]        pressure;
    logic               pen_up;
    logic [2:0]         down_inc;
    logic               med_start;
    logic               pass_end;
    logic [15:0]        alpha;
    logic signed [12:0] dx;
    logic signed [12:0] dy;
    logic signed [39:0] quo;
    logic signed [15:0] sat;
    logic               load_out;
    logic               load_pd;
    logic               load_ns;
    logic signed [15:0] load_x;
    logic signed [15:0] load_y;

    tsf_cfg_regs u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg), .regs(regs));
    tsf_median   u_med (.clk(clk), .rst_n(rst_n), .wr(med_wr), .start(med_start), .med(med));
    tsf_mac      u_mac (.clk(clk), .rst_n(rst_n), .op(mac_op), .acc(acc));

    assign samples.ready = (state_reg == ST_IDLE) && (!ovalid_reg || results.ready);
    assign accept        = samples.valid && samples.ready;

    assign pressure = (samples.z_one == 12'd0) ? 13'd0 :
                      13'(({1'b0, samples.z_one} + Z_OFFSET) - {1'b0, samples.z_two});
    assign pen_up   = pressure < regs.press_floor;
    assign down_inc = (down_reg < DOWN_MAX) ? down_reg + 3'd1 : down_reg;

    assign med_wr.en  = accept && (samples.opcode == OP_SAMPLE) &&
                        (idx_reg < CNT_W'(MEDIAN_COUNT));
    assign med_wr.idx = idx_reg[IDX_W-1:0];
    assign med_wr.x   = samples.x_sample;
    assign med_wr.y   = samples.y_sample;
    assign med_start  = accept && (samples.opcode == OP_CLOSE) && !pen_up;

    assign pass_end = (cnt_reg == 3'd4);
    assign alpha    = (lock_reg < LOCK_SLOW) ? ALPHA_FAST : ALPHA_SLOW;
    assign dx       = $signed({1'b0, med.rx}) - $signed({1'b0, prev_x_reg});
    assign dy       = $signed({1'b0, med.ry}) - $signed({1'b0, prev_y_reg});

    // op issue per pass slot
    always_comb
    begin
        mac_op.issue = 1'b0;
        mac_op.clr   = (cnt_reg == 3'd0);
        mac_op.init  = '0;
        mac_op.a     = '0;
        mac_op.b     = '0;
        unique case (state_reg)
            ST_JMP:
            begin
                mac_op.issue = (cnt_reg < 3'd3);
                case (cnt_reg)
                    3'd0:    begin mac_op.a = 33'(dx); mac_op.b = 21'(dx); end
                    3'd1:    begin mac_op.a = 33'(dy); mac_op.b = 21'(dy); end
                    default:
                    begin
                        mac_op.a = -$signed({21'd0, regs.jump_limit});
                        mac_op.b = $signed({9'd0, regs.jump_limit});
                    end
                endcase
            end
            ST_EWX, ST_EWY:
            begin
                mac_op.issue = (cnt_reg < 3'd2);
                mac_op.init  = 64'sd16384;
                if (cnt_reg == 3'd0)
                begin
                    mac_op.a = $signed({17'd0, alpha});
                    mac_op.b = $signed({1'b0, (state_reg == ST_EWX) ? med.rx : med.ry, 8'd0});
                end
                else
                begin
                    mac_op.a = $signed(33'(Q15_ONE - {1'b0, alpha}));
                    mac_op.b = $signed({1'b0, (state_reg == ST_EWX) ? sx_reg : sy_reg});
                end
            end
            ST_CALX, ST_CALY:
            begin
                mac_op.issue = (cnt_reg < 3'd3);
                case (cnt_reg)
                    3'd0:
                    begin
                        mac_op.a = 33'((state_reg == ST_CALX) ? regs.cal_ax : regs.cal_ay);
                        mac_op.b = $signed({1'b0, sx_reg});
                    end
                    3'd1:
                    begin
                        mac_op.a = 33'((state_reg == ST_CALX) ? regs.cal_bx : regs.cal_by);
                        mac_op.b = $signed({1'b0, sy_reg});
                    end
                    default:
                    begin
                        mac_op.a = 33'((state_reg == ST_CALX) ? regs.cal_cx : regs.cal_cy);
                        mac_op.b = 21'sd256;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // divide by 2^24 truncating toward zero, then clamp to 16 bits
    always_comb
    begin
        quo = acc[63:24];
        if (acc[63] && (acc[23:0] != 24'd0))
            quo = quo + 40'sd1;
        if (quo > 40'sd32767)
            sat = 16'sd32767;
        else if (quo < -40'sd32768)
            sat = -16'sd32768;
        else
            sat = quo[15:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (med_start) state_next = ST_MED;
            ST_MED:  if (med.done) state_next = ST_JMP;
            ST_JMP:  if (pass_end) state_next = ST_EWX;
            ST_EWX:  if (pass_end) state_next = ST_EWY;
            ST_EWY:  if (pass_end) state_next = ST_CALX;
            ST_CALX: if (pass_end) state_next = ST_CALY;
            ST_CALY: if (pass_end) state_next = ST_OUT;
            ST_OUT:  if (!ovalid_reg || results.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // result beat loading
    always_comb
    begin
        load_out = 1'b0;
        load_pd  = 1'b0;
        load_ns  = 1'b0;
        load_x   = '0;
        load_y   = '0;
        if (accept && (samples.opcode == OP_OPEN))
        begin
            load_out = 1'b1;
            load_ns  = !pen_up && (down_inc >= DOWN_DEB) && (down_inc > DOWN_REPORT);
        end
        else if (accept && (samples.opcode == OP_CLOSE) && pen_up)
        begin
            load_out = 1'b1;
        end
        else if ((state_reg == ST_OUT) && (!ovalid_reg || results.ready))
        begin
            load_out = 1'b1;
            load_pd  = 1'b1;
            load_x   = calx_reg;
            load_y   = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            down_reg   <= '0;
            lock_reg   <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 3'd0 : cnt_reg + 3'd1;

            if (accept && ((samples.opcode == OP_OPEN) || (samples.opcode == OP_CLOSE)) &&
                pen_up)
            begin
                down_reg <= '0;
                lock_reg <= '0;
            end
            else if (accept && (samples.opcode == OP_OPEN))
            begin
                down_reg <= down_inc;
                if (down_inc > DOWN_REPORT)
                    idx_reg <= '0;
            end

            if (med_wr.en)
                idx_reg <= idx_reg + CNT_W'(1);

            if (pass_end)
            begin
                unique case (state_reg)
                    ST_JMP:
                    begin
                        if ((lock_reg != 2'd0) && (acc > 64'sd0))
                            lock_reg <= '0;
                        prev_x_reg <= med.rx;
                        prev_y_reg <= med.ry;
                    end
                    ST_EWX:
                        sx_reg <= (lock_reg == 2'd0) ? {med.rx, 8'd0} : acc[34:15];
                    ST_EWY:
                    begin
                        sy_reg <= (lock_reg == 2'd0) ? {med.ry, 8'd0} : acc[34:15];
                        if (lock_reg < LOCK_MAX)
                            lock_reg <= lock_reg + 2'd1;
                    end
                    default: ;
                endcase
            end

            if (load_out)
                ovalid_reg <= 1'b1;
            else if (results.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_CALX) && pass_end)
            calx_reg <= sat;
        if (load_out)
        begin
            opd_reg   <= load_pd;
            ons_reg   <= load_ns;
            oposx_reg <= load_x;
            oposy_reg <= load_y;
        end
    end

    assign results.valid        = ovalid_reg;
    assign results.pen_down     = opd_reg;
    assign results.need_samples = ons_reg;
    assign results.pos_x        = oposx_reg;
    assign results.pos_y        = oposy_reg;

endmodule

@@ rtl/tsf_checker.sv @@
// Port-level checks of the touch filter, bound to the top level.
// Depends on tsf_pkg and touch_sample_filter_unit_defines.svh.
`include "touch_sample_filter_unit_defines.svh"

module tsf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic        pen_down,
    input logic        need_samples,
    input logic [15:0] pos_x,
    input logic [15:0] pos_y
);
    import tsf_pkg::*;

    `TSF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(pos_x), "result beat dropped")
    `TSF_ASSERT_SAME(a_zero_pos, out_valid && !pen_down, (pos_x == 16'd0) && (pos_y == 16'd0), "position not zero")
    `TSF_ASSERT_SAME(a_excl, out_valid, !(pen_down && need_samples), "pen_down with need_samples")
    `TSF_ASSERT_NEXT(a_no_spur, in_valid && in_ready && (in_opcode == OP_SAMPLE) && !out_valid, !out_valid, "sample beat made a result")

endmodule

bind touch_sample_filter_unit tsf_checker u_tsf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .in_opcode    (samples.opcode),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .pen_down     (results.pen_down),
    .need_samples (results.need_samples),
    .pos_x        (results.pos_x),
    .pos_y        (results.pos_y)
);

@@ tb/sv/tb_touch_sample_filter_unit.sv @@
// Self-checking bench for touch_sample_filter_unit: directed and random polls
// against an in-bench predictor. Depends on tsf_pkg, tsf_if and the RTL.
`timescale 1ns / 100ps

module tb_touch_sample_filter_unit;
    import tsf_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] z1;
        logic [11:0] z2;
        logic [11:0] x;
        logic [11:0] y;
    } touch_beat_t;

    typedef struct {
        logic               pen;
        logic               need;
        logic signed [15:0] px;
        logic signed [15:0] py;
    } touch_report_t;

    logic clk;
    logic rst_n;

    tsf_in_if  samples ();
    tsf_out_if results ();
    tsf_cfg_if cfg ();

    touch_sample_filter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg     (cfg)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predicted block state and registers
    int unsigned p_min, jump_lim;
    longint      k_ax, k_bx, k_cx, k_ay, k_by, k_cy;
    logic [2:0]  down_cnt;
    logic [1:0]  lock_cnt;
    logic [19:0] sm_x, sm_y;
    logic [11:0] last_mx, last_my;
    int unsigned st_x[MEDIAN_COUNT];
    int unsigned st_y[MEDIAN_COUNT];
    int unsigned st_idx;
    int unsigned st_filled;   // highest store entry ever written, plus one

    touch_report_t report_q[$];

    int unsigned send_idle, recv_idle;
    int unsigned errors, n_items, n_reports, n_fixes, n_asks, idle_cnt;
    int          walk_x, walk_y;

    function automatic int unsigned pressure(input logic [11:0] z1, input logic [11:0] z2);
        if (z1 == 12'd0)
            return 0;
        return int'(z1) + 4095 - int'(z2);
    endfunction

    function automatic int unsigned median7(input int unsigned v[MEDIAN_COUNT]);
        int unsigned t[MEDIAN_COUNT];
        int unsigned c;
        int          j;
        for (int i = 0; i < MEDIAN_COUNT; i++)
        begin
            c = v[i];
            j = i;
            while (j > 0 && t[j-1] > c)
            begin
                t[j] = t[j-1];
                j--;
            end
            t[j] = c;
        end
        return t[MEDIAN_COUNT/2];
    endfunction

    function automatic logic [19:0] smooth(input logic [19:0] old, input logic [11:0] raw,
                                           input longint alpha);
        longint acc;
        acc = alpha * (longint'(raw) << 8) + (32768 - alpha) * longint'(old) + 16384;
        return 20'(acc >>> 15);
    endfunction

    function automatic logic signed [15:0] screen(input longint a, input longint b,
                                                  input longint c);
        longint s, v;
        s = a * longint'(sm_x) + b * longint'(sm_y) + c * 256;
        v = s / (longint'(1) <<< 24);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    task automatic fold_beat(input touch_beat_t b);
        touch_report_t r;
        int unsigned   p, mx, my;
        int            dx, dy;
        r = '{1'b0, 1'b0, 16'sd0, 16'sd0};
        p = pressure(b.z1, b.z2);
        if (b.op == OP_OPEN)
        begin
            if (p < p_min)
            begin
                down_cnt = '0;
                lock_cnt = '0;
            end
            else
            begin
                if (down_cnt < DOWN_MAX)
                    down_cnt++;
                if (down_cnt > DOWN_REPORT)
                begin
                    st_idx = 0;
                    r.need = 1'b1;
                    n_asks++;
                end
            end
            report_q.push_back(r);
        end
        else if (b.op == OP_SAMPLE)
        begin
            if (st_idx < MEDIAN_COUNT)
            begin
                st_x[st_idx] = 32'(b.x);
                st_y[st_idx] = 32'(b.y);
                st_idx++;
                if (st_idx > st_filled)
                    st_filled = st_idx;
            end
        end
        else if (b.op == OP_CLOSE)
        begin
            if (p < p_min)
            begin
                down_cnt = '0;
                lock_cnt = '0;
            end
            else
            begin
                mx = median7(st_x);
                my = median7(st_y);
                if (lock_cnt != 0)
                begin
                    dx = int'(mx) - int'(last_mx);
                    dy = int'(my) - int'(last_my);
                    if (dx * dx + dy * dy > jump_lim * jump_lim)
                        lock_cnt = '0;
                end
                last_mx = 12'(mx);
                last_my = 12'(my);
                if (lock_cnt == 0)
                begin
                    sm_x = 20'(mx) << 8;
                    sm_y = 20'(my) << 8;
                    lock_cnt = 2'd1;
                end
                else
                begin
                    sm_x = smooth(sm_x, 12'(mx), (lock_cnt < LOCK_SLOW) ? ALPHA_FAST : ALPHA_SLOW);
                    sm_y = smooth(sm_y, 12'(my), (lock_cnt < LOCK_SLOW) ? ALPHA_FAST : ALPHA_SLOW);
                    if (lock_cnt < LOCK_MAX)
                        lock_cnt++;
                end
                r.pen = 1'b1;
                r.px  = screen(k_ax, k_bx, k_cx);
                r.py  = screen(k_ay, k_by, k_cy);
                n_fixes++;
            end
            report_q.push_back(r);
        end
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            n_reports++;
            if (report_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result pen=%0b need=%0b x=%0d y=%0d", $time,
                         results.pen_down, results.need_samples, results.pos_x, results.pos_y);
            end
            else
            begin
                touch_report_t e;
                e = report_q.pop_front();
                if (results.pen_down !== e.pen)
                begin
                    errors++;
                    $display("%0t: pen_down expected %0b got %0b", $time, e.pen,
                             results.pen_down);
                end
                if (results.need_samples !== e.need)
                begin
                    errors++;
                    $display("%0t: need_samples expected %0b got %0b", $time, e.need,
                             results.need_samples);
                end
                if (results.pos_x !== e.px)
                begin
                    errors++;
                    $display("%0t: pos_x expected %0d got %0d", $time, e.px, results.pos_x);
                end
                if (results.pos_y !== e.py)
                begin
                    errors++;
                    $display("%0t: pos_y expected %0d got %0d", $time, e.py, results.pos_y);
                end
            end
        end
        results.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready)
            || (cfg.valid && cfg.ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 3000)
        begin
            $display("touch_sample_filter_unit test failed");
            $finish;
        end
    end

    task automatic send_beat(input touch_beat_t b);
        // a pen-down close must never read unwritten store entries
        if (b.op == OP_CLOSE && st_filled < MEDIAN_COUNT && pressure(b.z1, b.z2) >= p_min)
            return;
        if ($urandom_range(0, 99) < send_idle)
        begin
            samples.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        samples.valid    <= 1'b1;
        samples.opcode   <= b.op;
        samples.z_one    <= b.z1;
        samples.z_two    <= b.z2;
        samples.x_sample <= b.x;
        samples.y_sample <= b.y;
        do
            @(posedge clk);
        while (!samples.ready);
        fold_beat(b);
        if (b.op != OP_SPARE)
            n_items++;
    endtask

    task automatic drain;
        samples.valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
        // xy samples give no result, so allow the block to settle
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            REG_PRESS_FLOOR:  p_min    = 32'(data[12:0]);
            REG_JUMP_LIMIT:   jump_lim = 32'(data[11:0]);
            REG_CAL_AX:       k_ax     = longint'($signed(data));
            REG_CAL_BX:       k_bx     = longint'($signed(data));
            REG_CAL_CX:       k_cx     = longint'($signed(data));
            REG_CAL_AY:       k_ay     = longint'($signed(data));
            REG_CAL_BY:       k_by     = longint'($signed(data));
            default:          k_cy     = longint'($signed(data));
        endcase
    endtask

    task automatic load_setup(input logic [31:0] pm, input logic [31:0] jl,
                              input logic [31:0] ax, input logic [31:0] bx,
                              input logic [31:0] cx, input logic [31:0] ay,
                              input logic [31:0] by, input logic [31:0] cy);
        write_reg(REG_PRESS_FLOOR, pm);
        write_reg(REG_JUMP_LIMIT, jl);
        write_reg(REG_CAL_AX, ax);
        write_reg(REG_CAL_BX, bx);
        write_reg(REG_CAL_CX, cx);
        write_reg(REG_CAL_AY, ay);
        write_reg(REG_CAL_BY, by);
        write_reg(REG_CAL_CY, cy);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic touch_beat_t press(input logic [1:0] op, input bit good);
        touch_beat_t b;
        int          lo, hi;
        b = '{op, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095))};
        if (good)
        begin
            lo = (int'(p_min) > 4096) ? int'(p_min) - 4095 : 1;
            b.z1 = 12'($urandom_range(lo, 4095));
            hi = int'(b.z1) + 4095 - int'(p_min);
            b.z2 = 12'($urandom_range(0, (hi > 4095) ? 4095 : hi));
        end
        return b;
    endfunction

    function automatic touch_beat_t xy_near;
        touch_beat_t b;
        int          vx, vy;
        b = '{OP_SAMPLE, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
              12'd0, 12'd0};
        if ($urandom_range(0, 9) == 0)
        begin
            b.x = 12'($urandom_range(0, 4095));
            b.y = 12'($urandom_range(0, 4095));
        end
        else
        begin
            vx = walk_x + int'($urandom_range(0, 60)) - 30;
            vy = walk_y + int'($urandom_range(0, 60)) - 30;
            b.x = (vx < 0) ? 12'd0 : (vx > 4095) ? 12'd4095 : 12'(vx);
            b.y = (vy < 0) ? 12'd0 : (vy > 4095) ? 12'd4095 : 12'(vy);
        end
        return b;
    endfunction

    task automatic run_polls(input int unsigned count);
        int unsigned goal, k;
        touch_beat_t b;
        goal = n_items + count;
        while (n_items < goal)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                b = press(2'($urandom_range(0, 3)), 1'b0);
                send_beat(b);
                continue;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                walk_x = $urandom_range(0, 4095);
                walk_y = $urandom_range(0, 4095);
            end
            else
            begin
                walk_x = walk_x + int'($urandom_range(0, 80)) - 40;
                walk_y = walk_y + int'($urandom_range(0, 80)) - 40;
            end
            send_beat(press(OP_OPEN, $urandom_range(0, 9) != 0));
            if (down_cnt > DOWN_REPORT || $urandom_range(0, 9) == 0)
            begin
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 9) : MEDIAN_COUNT;
                repeat (k) send_beat(xy_near());
                send_beat(press(OP_CLOSE, $urandom_range(0, 6) != 0));
            end
        end
    endtask

    task automatic test_directed;
        touch_beat_t b;
        send_beat('{OP_OPEN, 12'd0, 12'd0, 12'd0, 12'd0});          // zero z1 is pen up
        send_beat('{OP_OPEN, 12'd1, 12'd4095, 12'd0, 12'd0});       // pressure just 1
        repeat (5) send_beat('{OP_OPEN, 12'd4095, 12'd0, 12'd0, 12'd0});
        send_beat('{OP_SAMPLE, 12'd0, 12'd0, 12'd4095, 12'd0});
        send_beat('{OP_SAMPLE, 12'd0, 12'd0, 12'd0, 12'd4095});
        for (int i = 0; i < 5; i++)
            send_beat('{OP_SAMPLE, 12'd0, 12'd0, 12'(1000 + 50 * i), 12'(3000 - 40 * i)});
        send_beat('{OP_SAMPLE, 12'd0, 12'd0, 12'd4095, 12'd4095});  // store full, dropped
        send_beat('{OP_SPARE, 12'd4095, 12'd0, 12'd4095, 12'd4095}); // unused opcode
        send_beat('{OP_CLOSE, 12'd4095, 12'd0, 12'd0, 12'd0});
        send_beat('{OP_CLOSE, 12'd2048, 12'd2048, 12'd0, 12'd0});   // reuses old store
        send_beat('{OP_CLOSE, 12'd0, 12'd4095, 12'd0, 12'd0});      // pen lifts on close
        send_beat('{OP_CLOSE, 12'd4095, 12'd4095, 12'd0, 12'd0});   // snap after unlock
        b = '{OP_OPEN, 12'd0, 12'd0, 12'd0, 12'd0};
        send_beat(b);
    endtask

    task automatic test_reset_setup;
        test_directed();
        run_polls(180);
        drain();
    endtask

    task automatic test_loose_saturating;
        load_setup(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hFFFD_0000, 32'h0002_0000, 32'h8000_0000);
        run_polls(150);
        drain();
    endtask

    task automatic test_strict_pressure;
        load_setup(32'd8190, 32'd4095, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        run_polls(100);
        drain();
    endtask

    task automatic test_random_setups;
        repeat (4)
        begin
            load_setup($urandom_range(0, 2000), $urandom_range(20, 600),
                       32'($urandom_range(0, 262144)) - 32'd131072,
                       32'($urandom_range(0, 65536)) - 32'd32768,
                       32'($urandom_range(0, 33554432)) - 32'd16777216,
                       32'($urandom_range(0, 65536)) - 32'd32768,
                       32'($urandom_range(0, 262144)) - 32'd131072,
                       $urandom());
            run_polls(55);
            drain();
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        samples.valid    = 1'b0;
        samples.opcode   = OP_OPEN;
        samples.z_one    = '0;
        samples.z_two    = '0;
        samples.x_sample = '0;
        samples.y_sample = '0;
        results.ready    = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = REG_PRESS_FLOOR;
        cfg.data         = '0;
        errors = 0; n_items = 0; n_reports = 0; n_fixes = 0; n_asks = 0; idle_cnt = 0;
        p_min = 100; jump_lim = 300;
        k_ax = 65536; k_bx = 0; k_cx = 0; k_ay = 0; k_by = 65536; k_cy = 0;
        down_cnt = '0; lock_cnt = '0; sm_x = '0; sm_y = '0; last_mx = '0; last_my = '0;
        st_idx = 0; st_filled = 0;
        for (int i = 0; i < MEDIAN_COUNT; i++)
        begin
            st_x[i] = 0;
            st_y[i] = 0;
        end
        walk_x = 2048; walk_y = 2048;
        send_idle = 18; recv_idle = 50;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_setup();
        send_idle = 50; recv_idle = 18;
        test_loose_saturating();
        send_idle = 0; recv_idle = 0;
        test_strict_pressure();
        test_random_setups();

        $display("Sent %0d beats; %0d results checked, %0d sample requests, %0d positions.",
                 n_items, n_reports, n_asks, n_fixes);
        $display("Register settings: reset values, both extremes and four random setups.");
        if (errors == 0)
            $display("touch_sample_filter_unit test passed");
        else
            $display("touch_sample_filter_unit test failed");
        $finish;
    end

endmodule
